// ===== rtl/core/qrcuv_pkg.sv =====
// Package for the quad clip core: shared widths, default parameter values,
// configuration register indexes and the controller-to-datapath command types.
// No dependencies.
package qrcuv_pkg;

	// Default parameter values and fixed field widths.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int TEX_WIDTH_DEF   = 16;
	localparam int DIM_W           = 31;
	localparam int COUNT_W         = 30;
	localparam int BASE_W          = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int SEL_W           = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 1'b1;

	// Ratio slots, in the order the controller walks them.
	localparam logic [SEL_W-1:0] SLOT_U_LEFT   = 2'd0;
	localparam logic [SEL_W-1:0] SLOT_U_RIGHT  = 2'd1;
	localparam logic [SEL_W-1:0] SLOT_V_BOTTOM = 2'd2;
	localparam logic [SEL_W-1:0] SLOT_V_TOP    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             accept;
		logic             check;
		logic             div_load;
		logic             div_step;
		logic             mul;
		logic             store;
		logic             out_load;
		logic [SEL_W-1:0] sel;
	} qrcuv_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic drop;
	} qrcuv_stat_t;

endpackage

// ===== rtl/core/quad_rect_clip_uv_core.sv =====
// Top level of the quad clip core: connects the controller and the datapath.
// Depends on qrcuv_pkg, qrcuv_ctrl and qrcuv_dp.
//
//   Channel  Handshake            Carries
//   in       in_valid / in_stall  first_of_text, quad edges, edge texture coordinates
//   out      out_valid/out_stall  kept, clipped edges and texture coords, base_vertex
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (rect_width, rect_height)
//
// For a kept quad the one shared divider produces one quotient bit per
// cycle for each of the four texture ratios in turn; a dropped quad skips
// the divider. A new request is accepted as soon as the previous result
// sits in the output register, even while it is stalled.
// Reset clears the controller, the kept quad count and both rectangle registers.
module quad_rect_clip_uv_core #(
	parameter int COORD_WIDTH = qrcuv_pkg::COORD_WIDTH_DEF,
	parameter int TEX_WIDTH   = qrcuv_pkg::TEX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              first_of_text,
	input  logic signed [COORD_WIDTH-1:0]     quad_left,
	input  logic signed [COORD_WIDTH-1:0]     quad_right,
	input  logic signed [COORD_WIDTH-1:0]     quad_bottom,
	input  logic signed [COORD_WIDTH-1:0]     quad_top,
	input  logic [TEX_WIDTH-1:0]              tex_u_left,
	input  logic [TEX_WIDTH-1:0]              tex_u_right,
	input  logic [TEX_WIDTH-1:0]              tex_v_bottom,
	input  logic [TEX_WIDTH-1:0]              tex_v_top,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kept,
	output logic signed [COORD_WIDTH-1:0]     clip_left,
	output logic signed [COORD_WIDTH-1:0]     clip_right,
	output logic signed [COORD_WIDTH-1:0]     clip_bottom,
	output logic signed [COORD_WIDTH-1:0]     clip_top,
	output logic [TEX_WIDTH-1:0]              clip_u_left,
	output logic [TEX_WIDTH-1:0]              clip_u_right,
	output logic [TEX_WIDTH-1:0]              clip_v_bottom,
	output logic [TEX_WIDTH-1:0]              clip_v_top,
	output logic [qrcuv_pkg::BASE_W-1:0]      base_vertex,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qrcuv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qrcuv_pkg::DIM_W-1:0]       cfg_data
);

	qrcuv_pkg::qrcuv_cmd_t  cmd;
	qrcuv_pkg::qrcuv_stat_t stat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	qrcuv_ctrl #(
		.TW(TEX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	qrcuv_dp #(
		.CW(COORD_WIDTH),
		.TW(TEX_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.first_of_text (first_of_text),
		.quad_left     (quad_left),
		.quad_right    (quad_right),
		.quad_bottom   (quad_bottom),
		.quad_top      (quad_top),
		.tex_u_left    (tex_u_left),
		.tex_u_right   (tex_u_right),
		.tex_v_bottom  (tex_v_bottom),
		.tex_v_top     (tex_v_top),
		.kept          (kept),
		.clip_left     (clip_left),
		.clip_right    (clip_right),
		.clip_bottom   (clip_bottom),
		.clip_top      (clip_top),
		.clip_u_left   (clip_u_left),
		.clip_u_right  (clip_u_right),
		.clip_v_bottom (clip_v_bottom),
		.clip_v_top    (clip_v_top),
		.base_vertex   (base_vertex)
	);

endmodule

// ===== rtl/core/qrcuv_ctrl.sv =====
// Controller of the quad clip core: sequences check, four divisions,
// multiplies and result writes, and owns the request handshakes.
// Depends on qrcuv_pkg.
module qrcuv_ctrl #(
	parameter int TW = qrcuv_pkg::TEX_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	input  qrcuv_pkg::qrcuv_stat_t  stat,
	output qrcuv_pkg::qrcuv_cmd_t   cmd
);

	localparam int CNT_W = $clog2(TW + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_STORE,
		ST_WRITE
	} state_t;

	state_t                        state_q;
	logic [qrcuv_pkg::SEL_W-1:0]   sel_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          out_valid_q;
	logic                          out_free;

	// The output register can take a result when empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd          = '0;
		cmd.sel      = sel_q;
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.check    = (state_q == ST_CHECK);
		cmd.div_load = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul      = (state_q == ST_MUL);
		cmd.store    = (state_q == ST_STORE);
		cmd.out_load = (state_q == ST_WRITE) && out_free;
	end

	// State, slot counter, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= qrcuv_pkg::SLOT_U_LEFT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					sel_q <= qrcuv_pkg::SLOT_U_LEFT;
					if (stat.drop) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TW)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					if (sel_q == qrcuv_pkg::SLOT_V_TOP) begin
						state_q <= ST_WRITE;
					end else begin
						sel_q   <= sel_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/qrcuv_dp.sv =====
// Datapath of the quad clip core: configuration registers, input capture,
// clip test and clamp, shared restoring divider, multiplier and result registers.
// Depends on qrcuv_pkg.
module qrcuv_dp #(
	parameter int CW = qrcuv_pkg::COORD_WIDTH_DEF,
	parameter int TW = qrcuv_pkg::TEX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qrcuv_pkg::qrcuv_cmd_t             cmd,
	output qrcuv_pkg::qrcuv_stat_t            stat,
	input  logic                              cfg_we,
	input  logic [qrcuv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qrcuv_pkg::DIM_W-1:0]       cfg_data,
	input  logic                              first_of_text,
	input  logic signed [CW-1:0]              quad_left,
	input  logic signed [CW-1:0]              quad_right,
	input  logic signed [CW-1:0]              quad_bottom,
	input  logic signed [CW-1:0]              quad_top,
	input  logic [TW-1:0]                     tex_u_left,
	input  logic [TW-1:0]                     tex_u_right,
	input  logic [TW-1:0]                     tex_v_bottom,
	input  logic [TW-1:0]                     tex_v_top,
	output logic                              kept,
	output logic signed [CW-1:0]              clip_left,
	output logic signed [CW-1:0]              clip_right,
	output logic signed [CW-1:0]              clip_bottom,
	output logic signed [CW-1:0]              clip_top,
	output logic [TW-1:0]                     clip_u_left,
	output logic [TW-1:0]                     clip_u_right,
	output logic [TW-1:0]                     clip_v_bottom,
	output logic [TW-1:0]                     clip_v_top,
	output logic [qrcuv_pkg::BASE_W-1:0]      base_vertex
);

	localparam int DW = qrcuv_pkg::DIM_W;
	localparam int EW = ((CW > DW) ? CW : DW) + 2;
	localparam int NW = CW + 1;
	localparam int RW = CW + 2;
	localparam int QW = TW + 1;
	localparam int PW = TW + QW;
	localparam int NSLOT = 1 << qrcuv_pkg::SEL_W;

	// Configuration registers.
	logic [DW-1:0] rect_w_q, rect_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_w_q <= '0;
			rect_h_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qrcuv_pkg::CFG_RECT_WIDTH:  rect_w_q <= cfg_data;
				qrcuv_pkg::CFG_RECT_HEIGHT: rect_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Captured request.
	logic signed [CW-1:0] left_q, right_q, bottom_q, top_q;
	logic [TW-1:0]        ul_q, ur_q, vb_q, vt_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			left_q   <= quad_left;
			right_q  <= quad_right;
			bottom_q <= quad_bottom;
			top_q    <= quad_top;
			ul_q     <= tex_u_left;
			ur_q     <= tex_u_right;
			vb_q     <= tex_v_bottom;
			vt_q     <= tex_v_top;
		end
	end

	// Kept quad counter; a first-of-text request clears it before the test.
	logic [qrcuv_pkg::COUNT_W-1:0] count_q;
	logic                          kept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept && first_of_text) begin
			count_q <= '0;
		end else if (cmd.out_load && kept_q) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Clip test and clamp on sign-extended edges against the half extents.
	logic signed [EW-1:0] left_e, right_e, bottom_e, top_e;
	logic signed [EW-1:0] hw_e, hh_e, nhw_e, nhh_e;
	logic signed [EW-1:0] cl_e, cr_e, cb_e, ct_e;
	logic                 drop;

	always_comb begin
		left_e   = EW'(left_q);
		right_e  = EW'(right_q);
		bottom_e = EW'(bottom_q);
		top_e    = EW'(top_q);
		hw_e     = $signed(EW'(rect_w_q[DW-1:1]));
		hh_e     = $signed(EW'(rect_h_q[DW-1:1]));
		nhw_e    = -hw_e;
		nhh_e    = -hh_e;
		drop     = (rect_w_q == '0) || (rect_h_q == '0) ||
		           (left_e >= hw_e) || (right_e <= nhw_e) ||
		           (bottom_e >= hh_e) || (top_e <= nhh_e) ||
		           (right_e <= left_e) || (top_e <= bottom_e);
		cl_e     = (left_e > nhw_e) ? left_e : nhw_e;
		cr_e     = (right_e < hw_e) ? right_e : hw_e;
		cb_e     = (bottom_e > nhh_e) ? bottom_e : nhh_e;
		ct_e     = (top_e < hh_e) ? top_e : hh_e;
	end

	assign stat.drop = drop;

	// Clamped edges, ratio numerators and spans; a kept quad's values fit.
	logic signed [CW-1:0] cl_q, cr_q, cb_q, ct_q;
	logic [NW-1:0]        num_q [NSLOT];
	logic [NW-1:0]        dx_q, dy_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			kept_q   <= !drop;
			cl_q     <= CW'(cl_e);
			cr_q     <= CW'(cr_e);
			cb_q     <= CW'(cb_e);
			ct_q     <= CW'(ct_e);
			num_q[qrcuv_pkg::SLOT_U_LEFT]   <= NW'(cl_e - left_e);
			num_q[qrcuv_pkg::SLOT_U_RIGHT]  <= NW'(cr_e - left_e);
			num_q[qrcuv_pkg::SLOT_V_BOTTOM] <= NW'(cb_e - bottom_e);
			num_q[qrcuv_pkg::SLOT_V_TOP]    <= NW'(ct_e - bottom_e);
			dx_q     <= NW'(right_e - left_e);
			dy_q     <= NW'(top_e - bottom_e);
		end
	end

	// Shared restoring divider, one quotient bit per cycle.
	logic [RW-1:0] rem_q, rem_diff;
	logic [NW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic          rem_ge;
	logic [NW-1:0] num_sel, den_sel;

	always_comb begin
		num_sel  = num_q[cmd.sel];
		den_sel  = cmd.sel[1] ? dy_q : dx_q;
		rem_ge   = (rem_q >= RW'(den_q));
		rem_diff = rem_ge ? (rem_q - RW'(den_q)) : rem_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= RW'(num_sel);
			den_q <= den_sel;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {rem_diff[RW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], rem_ge};
		end
	end

	// Texture span magnitude times ratio, registered.
	logic [TW-1:0] t_start, t_end, t_mag, start_q;
	logic          t_neg, neg_q;
	logic [PW-1:0] prod_q;

	always_comb begin
		t_start = cmd.sel[1] ? vb_q : ul_q;
		t_end   = cmd.sel[1] ? vt_q : ur_q;
		t_neg   = (t_end < t_start);
		t_mag   = t_neg ? (t_start - t_end) : (t_end - t_start);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q  <= PW'(t_mag) * PW'(quo_q);
			neg_q   <= t_neg;
			start_q <= t_start;
		end
	end

	// Step toward the end value, truncated toward the start.
	logic [QW-1:0] t_step;
	logic [TW-1:0] t_res;
	logic [TW-1:0] tex_q [NSLOT];

	always_comb begin
		t_step = prod_q[PW-1:TW];
		t_res  = neg_q ? TW'(QW'(start_q) - t_step) : TW'(QW'(start_q) + t_step);
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			tex_q[cmd.sel] <= t_res;
		end
	end

	// Output register; a dropped quad shows zeros in every field.
	logic                           o_kept_q;
	logic signed [CW-1:0]           o_left_q, o_right_q, o_bottom_q, o_top_q;
	logic [TW-1:0]                  o_ul_q, o_ur_q, o_vb_q, o_vt_q;
	logic [qrcuv_pkg::BASE_W-1:0]   o_base_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_kept_q   <= kept_q;
			o_left_q   <= kept_q ? cl_q : '0;
			o_right_q  <= kept_q ? cr_q : '0;
			o_bottom_q <= kept_q ? cb_q : '0;
			o_top_q    <= kept_q ? ct_q : '0;
			o_ul_q     <= kept_q ? tex_q[qrcuv_pkg::SLOT_U_LEFT] : '0;
			o_ur_q     <= kept_q ? tex_q[qrcuv_pkg::SLOT_U_RIGHT] : '0;
			o_vb_q     <= kept_q ? tex_q[qrcuv_pkg::SLOT_V_BOTTOM] : '0;
			o_vt_q     <= kept_q ? tex_q[qrcuv_pkg::SLOT_V_TOP] : '0;
			o_base_q   <= kept_q ? {count_q, 2'b00} : '0;
		end
	end

	assign kept          = o_kept_q;
	assign clip_left     = o_left_q;
	assign clip_right    = o_right_q;
	assign clip_bottom   = o_bottom_q;
	assign clip_top      = o_top_q;
	assign clip_u_left   = o_ul_q;
	assign clip_u_right  = o_ur_q;
	assign clip_v_bottom = o_vb_q;
	assign clip_v_top    = o_vt_q;
	assign base_vertex   = o_base_q;

endmodule

// ===== rtl/core/qrcuv_checker.sv =====
// Port-level checker for the quad clip core and its bind to the top level.
// Depends on qrcuv_pkg and quad_rect_clip_uv_core.
module qrcuv_checker #(
	parameter int CW = qrcuv_pkg::COORD_WIDTH_DEF,
	parameter int TW = qrcuv_pkg::TEX_WIDTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            kept,
	input logic signed [CW-1:0]            clip_left,
	input logic signed [CW-1:0]            clip_right,
	input logic signed [CW-1:0]            clip_bottom,
	input logic signed [CW-1:0]            clip_top,
	input logic [TW-1:0]                   clip_u_left,
	input logic [qrcuv_pkg::BASE_W-1:0]    base_vertex
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// One request at a time: an accepted request blocks the next cycle.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// A dropped quad carries zeros.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kept |-> base_vertex == '0 && clip_left == '0 &&
			clip_top == '0 && clip_u_left == '0)
		else $error("dropped quad with nonzero fields");

	// A kept quad keeps its edges in order after clamping; a half extent of
	// zero clamps both edges onto the axis.
	a_kept_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kept |-> clip_left <= clip_right && clip_bottom <= clip_top)
		else $error("kept quad has its edges out of order");

	// Base vertex steps by four vertices per kept quad, so it stays a multiple of four.
	a_base_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> base_vertex[1:0] == 2'b00)
		else $error("base vertex not a multiple of four");

endmodule

bind quad_rect_clip_uv_core qrcuv_checker #(
	.CW(COORD_WIDTH),
	.TW(TEX_WIDTH)
) u_qrcuv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kept        (kept),
	.clip_left   (clip_left),
	.clip_right  (clip_right),
	.clip_bottom (clip_bottom),
	.clip_top    (clip_top),
	.clip_u_left (clip_u_left),
	.base_vertex (base_vertex)
);

// ===== verif/quad_rect_clip_uv_core_tb.sv =====
// Testbench for quad_rect_clip_uv_core: directed and random glyph quads checked
// against a behavioral predictor of the clip and texture reinterpolation.
// Depends on qrcuv_pkg and the quad_rect_clip_uv_core RTL.
module quad_rect_clip_uv_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = qrcuv_pkg::COORD_WIDTH_DEF;
	localparam int TW = qrcuv_pkg::TEX_WIDTH_DEF;
	localparam int DW = qrcuv_pkg::DIM_W;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 125;
	localparam longint CMIN = -64'sd2147483648;
	localparam longint CMAX = 64'sd2147483647;
	localparam logic [DW-1:0] DIM_MAX = {DW{1'b1}};

	// One quad request and one clip result, at the block's widths.
	typedef struct packed {
		logic                 first_of_text;
		logic signed [CW-1:0] left;
		logic signed [CW-1:0] right;
		logic signed [CW-1:0] bottom;
		logic signed [CW-1:0] top;
		logic [TW-1:0]        u_left;
		logic [TW-1:0]        u_right;
		logic [TW-1:0]        v_bottom;
		logic [TW-1:0]        v_top;
	} quad_req_t;

	typedef struct packed {
		logic                           kept;
		logic signed [CW-1:0]           left;
		logic signed [CW-1:0]           right;
		logic signed [CW-1:0]           bottom;
		logic signed [CW-1:0]           top;
		logic [TW-1:0]                  u_left;
		logic [TW-1:0]                  u_right;
		logic [TW-1:0]                  v_bottom;
		logic [TW-1:0]                  v_top;
		logic [qrcuv_pkg::BASE_W-1:0]   base_vertex;
	} clip_res_t;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic                                first_of_text;
	logic signed [CW-1:0]                quad_left;
	logic signed [CW-1:0]                quad_right;
	logic signed [CW-1:0]                quad_bottom;
	logic signed [CW-1:0]                quad_top;
	logic [TW-1:0]                       tex_u_left;
	logic [TW-1:0]                       tex_u_right;
	logic [TW-1:0]                       tex_v_bottom;
	logic [TW-1:0]                       tex_v_top;
	logic                                out_valid;
	logic                                out_stall;
	logic                                kept;
	logic signed [CW-1:0]                clip_left;
	logic signed [CW-1:0]                clip_right;
	logic signed [CW-1:0]                clip_bottom;
	logic signed [CW-1:0]                clip_top;
	logic [TW-1:0]                       clip_u_left;
	logic [TW-1:0]                       clip_u_right;
	logic [TW-1:0]                       clip_v_bottom;
	logic [TW-1:0]                       clip_v_top;
	logic [qrcuv_pkg::BASE_W-1:0]        base_vertex;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [qrcuv_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [DW-1:0]                       cfg_data;

	// Predictor state: the rectangle as written and the kept quad count.
	logic [DW-1:0]                  rect_w_model;
	logic [DW-1:0]                  rect_h_model;
	logic [qrcuv_pkg::COUNT_W-1:0]  kept_quads;

	clip_res_t expected_clips[$];
	clip_res_t want;
	int        error_count;
	int        result_idx;
	bit        no_idle;

	quad_rect_clip_uv_core dut (.*);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR: %s", msg);
		error_count++;
	endtask

	// Truncated ratio of num over den with TW fraction bits, one bit at a time.
	function automatic logic [TW:0] edge_ratio(input longint unsigned num,
			input longint unsigned den);
		longint unsigned rem;
		logic [TW:0]     q;
		q = '0;
		rem = num;
		if (rem >= den) begin
			q[0] = 1'b1;
			rem -= den;
		end
		for (int i = 0; i < TW; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem -= den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// Moves from lo_tex toward hi_tex by the ratio, truncating toward lo_tex.
	function automatic logic [TW-1:0] tex_lerp(input logic [TW-1:0] lo_tex,
			input logic [TW-1:0] hi_tex, input logic [TW:0] ratio);
		longint d;
		longint mag;
		longint step_amt;
		longint res;
		d = longint'(hi_tex) - longint'(lo_tex);
		mag = (d < 0) ? -d : d;
		step_amt = (mag * longint'(ratio)) >>> TW;
		res = (d < 0) ? longint'(lo_tex) - step_amt : longint'(lo_tex) + step_amt;
		return res[TW-1:0];
	endfunction

	// Expected result of one quad; advances the kept quad count.
	function automatic clip_res_t clip_quad(input quad_req_t q);
		longint    l, r, b, t, hw, hh, cl, cr, cb, ct;
		clip_res_t res;
		l = longint'($signed(q.left));
		r = longint'($signed(q.right));
		b = longint'($signed(q.bottom));
		t = longint'($signed(q.top));
		hw = longint'(rect_w_model >> 1);
		hh = longint'(rect_h_model >> 1);
		res = '0;
		if (q.first_of_text)
			kept_quads = '0;
		if (rect_w_model == 0 || rect_h_model == 0 || l >= hw || r <= -hw ||
				b >= hh || t <= -hh || r <= l || t <= b)
			return res;
		cl = (l > -hw) ? l : -hw;
		cr = (r < hw) ? r : hw;
		cb = (b > -hh) ? b : -hh;
		ct = (t < hh) ? t : hh;
		res.kept = 1'b1;
		res.left = cl[CW-1:0];
		res.right = cr[CW-1:0];
		res.bottom = cb[CW-1:0];
		res.top = ct[CW-1:0];
		res.u_left = tex_lerp(q.u_left, q.u_right, edge_ratio(cl - l, r - l));
		res.u_right = tex_lerp(q.u_left, q.u_right, edge_ratio(cr - l, r - l));
		res.v_bottom = tex_lerp(q.v_bottom, q.v_top, edge_ratio(cb - b, t - b));
		res.v_top = tex_lerp(q.v_bottom, q.v_top, edge_ratio(ct - b, t - b));
		res.base_vertex = {kept_quads, 2'b00};
		kept_quads = kept_quads + 1'b1;
		return res;
	endfunction

	function automatic longint fx(input int n);
		return longint'(n) * 65536;
	endfunction

	function automatic quad_req_t make_quad(input logic first, input longint l,
			input longint r, input longint b, input longint t, input logic [TW-1:0] ul,
			input logic [TW-1:0] ur, input logic [TW-1:0] vb, input logic [TW-1:0] vt);
		quad_req_t q;
		q.first_of_text = first;
		q.left = l[CW-1:0];
		q.right = r[CW-1:0];
		q.bottom = b[CW-1:0];
		q.top = t[CW-1:0];
		q.u_left = ul;
		q.u_right = ur;
		q.v_bottom = vb;
		q.v_top = vt;
		return q;
	endfunction

	// A coordinate around a rectangle edge pair of half extent half.
	function automatic longint near_coord(input longint half);
		longint span;
		span = 3 * half + 3;
		return (longint'($urandom) % span) - span / 2;
	endfunction

	// Mostly well-formed quads near the rectangle; some noise and bad shapes.
	function automatic quad_req_t random_quad(input logic first);
		quad_req_t q;
		longint    a, b, c, d, hw, hh;
		int        shape;
		hw = longint'(rect_w_model >> 1);
		hh = longint'(rect_h_model >> 1);
		shape = $urandom_range(0, 19);
		if (shape == 0) begin
			q.left = CW'($urandom);
			q.right = CW'($urandom);
			q.bottom = CW'($urandom);
			q.top = CW'($urandom);
		end else begin
			a = near_coord(hw);
			b = near_coord(hw);
			c = near_coord(hh);
			d = near_coord(hh);
			if (shape == 1)
				b = a;
			q.left = (a < b) ? a[CW-1:0] : b[CW-1:0];
			q.right = (a < b) ? b[CW-1:0] : a[CW-1:0];
			// An inverted quad has its bottom above its top.
			if (shape == 2) begin
				q.bottom = (c < d) ? d[CW-1:0] : c[CW-1:0];
				q.top = (c < d) ? c[CW-1:0] : d[CW-1:0];
			end else begin
				q.bottom = (c < d) ? c[CW-1:0] : d[CW-1:0];
				q.top = (c < d) ? d[CW-1:0] : c[CW-1:0];
			end
		end
		q.first_of_text = first;
		q.u_left = TW'($urandom);
		q.u_right = TW'($urandom);
		q.v_bottom = TW'($urandom);
		q.v_top = TW'($urandom);
		return q;
	endfunction

	// Sends one request after a random gap, or none while no_idle is set, and records its expected result.
	task automatic send_quad(input quad_req_t q);
		int        gap;
		clip_res_t exp_res;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_of_text <= q.first_of_text;
		quad_left <= q.left;
		quad_right <= q.right;
		quad_bottom <= q.bottom;
		quad_top <= q.top;
		tex_u_left <= q.u_left;
		tex_u_right <= q.u_right;
		tex_v_bottom <= q.v_bottom;
		tex_v_top <= q.v_top;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		exp_res = clip_quad(q);
		expected_clips.insert(expected_clips.size(), exp_res);
	endtask

	// Lowers the request and waits until every expected result is back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_clips.size() != 0) @(posedge clk);
	endtask

	// Writes both rectangle registers back to back; the block must be idle.
	task automatic set_rect(input logic [DW-1:0] w, input logic [DW-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= qrcuv_pkg::CFG_RECT_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rect_w_model = w;
		cfg_index <= qrcuv_pkg::CFG_RECT_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rect_h_model = h;
		cfg_valid <= 1'b0;
	endtask

	// A zero width or height drops every quad.
	task automatic test_zero_rect();
		send_quad(make_quad(1'b1, fx(-10), fx(10), fx(-5), fx(5),
			16'h1000, 16'hF000, 16'h0000, 16'hFFFF));
		drain();
		set_rect(DW'(fx(100)), '0);
		send_quad(make_quad(1'b0, fx(-10), fx(10), fx(-5), fx(5),
			16'h1000, 16'hF000, 16'h0000, 16'hFFFF));
		drain();
		set_rect('0, DW'(fx(100)));
		send_quad(make_quad(1'b0, fx(-10), fx(10), fx(-5), fx(5),
			16'h1000, 16'hF000, 16'h0000, 16'hFFFF));
		drain();
	endtask

	// Clamping on each side, strict outside tests, degenerate quads and restarts.
	task automatic test_clip_cases();
		set_rect(DW'(fx(100)), DW'(fx(60)));
		send_quad(make_quad(1'b1, fx(-10), fx(10), fx(-5), fx(5),
			16'h1000, 16'hF000, 16'h0000, 16'hFFFF));
		send_quad(make_quad(1'b0, fx(-80), fx(20), fx(-45), fx(10),
			16'hFFFF, 16'h0000, 16'h8000, 16'h0001));
		send_quad(make_quad(1'b0, fx(-20) + 7, fx(75) + 3, fx(-10), fx(40) + 1,
			16'h1234, 16'hABCD, 16'hFFFF, 16'h0000));
		send_quad(make_quad(1'b0, fx(-300), fx(300), fx(-200), fx(200),
			16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
		// Quads that only touch the rectangle from outside are dropped; the last one overlaps by one unit and is kept.
		send_quad(make_quad(1'b0, fx(50), fx(90), fx(-5), fx(5),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		send_quad(make_quad(1'b0, fx(-90), fx(-50), fx(-5), fx(5),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		send_quad(make_quad(1'b0, fx(-5), fx(5), fx(30), fx(40),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		send_quad(make_quad(1'b0, fx(-5), fx(5), fx(-40), fx(-30),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		send_quad(make_quad(1'b0, fx(50) - 1, fx(51), fx(-30), fx(-30) + 1,
			16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
		// Zero width, then a quad with its top below its bottom.
		send_quad(make_quad(1'b0, fx(3), fx(3), fx(-5), fx(5),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		send_quad(make_quad(1'b0, fx(-5), fx(5), fx(5), fx(-5),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		// A restart on a dropped quad still clears the count.
		send_quad(make_quad(1'b1, fx(1), fx(1), fx(-5), fx(5),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		send_quad(make_quad(1'b0, fx(-1), fx(1), fx(-1), fx(1),
			16'h0100, 16'h0200, 16'h0300, 16'h0400));
		send_quad(make_quad(1'b0, CMIN, CMAX, CMIN, CMAX,
			16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
		drain();
	endtask

	// Largest rectangle, and rectangles with half extents of one and zero.
	task automatic test_rect_extremes();
		set_rect(DIM_MAX, DIM_MAX);
		send_quad(make_quad(1'b1, CMIN, CMAX, CMIN, CMAX,
			16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
		drain();
		set_rect(DW'(3), DW'(3));
		send_quad(make_quad(1'b0, -5, 5, -5, 5, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000));
		send_quad(make_quad(1'b0, 0, 1, -1, 0, 16'hFFFF, 16'h0001, 16'h0002, 16'hFFFE));
		drain();
		// A width of one truncates to a half extent of zero.
		set_rect(DW'(1), DW'(1));
		send_quad(make_quad(1'b0, -5, 5, -5, 5, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
		drain();
	endtask

	// Runs of texts under several rectangles, each text usually opening with a restart.
	task automatic test_random_texts();
		int            sent;
		int            text_len;
		logic          first;
		logic [DW-1:0] w, h;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					w = DIM_MAX;
					h = DIM_MAX;
				end
				1: begin
					w = DW'(2);
					h = DW'(3);
				end
				2: begin
					w = DW'($urandom_range(1 << 16, 1 << 24));
					h = DW'($urandom_range(1 << 16, 1 << 24));
				end
				3: begin
					w = DIM_MAX;
					h = DW'($urandom_range(1, 1 << 20));
				end
				4: begin
					w = DW'($urandom_range(1, DIM_MAX));
					h = DW'($urandom_range(1, DIM_MAX));
				end
				default: begin
					w = DW'($urandom_range(1, 4096) | 1);
					h = DW'($urandom_range(1, 4096) | 1);
				end
			endcase
			set_rect(w, h);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				text_len = $urandom_range(1, 24);
				no_idle = ($urandom_range(0, 4) == 0);
				for (int k = 0; k < text_len && sent < PHASE_ITEMS; k++) begin
					if (k == 0)
						first = ($urandom_range(0, 19) != 0);
					else
						first = ($urandom_range(0, 29) == 0);
					send_quad(random_quad(first));
					sent++;
				end
			end
			no_idle = 1'b0;
			drain();
		end
	endtask

	// Result side stall: a random hold before each result is taken.
	initial begin : result_stall
		int hold;
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (got !== exp_val)
			report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				result_idx, name, got, exp_val));
	endtask

	// Compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_clips.size() == 0) begin
				report_error($sformatf("result %0d arrived with no request pending",
					result_idx));
			end else begin
				want = expected_clips.pop_front();
				check_field("kept", 64'(kept), 64'(want.kept));
				check_field("clip_left", 64'(clip_left), 64'(want.left));
				check_field("clip_right", 64'(clip_right), 64'(want.right));
				check_field("clip_bottom", 64'(clip_bottom), 64'(want.bottom));
				check_field("clip_top", 64'(clip_top), 64'(want.top));
				check_field("clip_u_left", 64'(clip_u_left), 64'(want.u_left));
				check_field("clip_u_right", 64'(clip_u_right), 64'(want.u_right));
				check_field("clip_v_bottom", 64'(clip_v_bottom), 64'(want.v_bottom));
				check_field("clip_v_top", 64'(clip_v_top), 64'(want.v_top));
				check_field("base_vertex", 64'(base_vertex), 64'(want.base_vertex));
			end
			result_idx++;
		end
	end

	// Ends the run when no handshake completes for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Main sequence: reset, then each test in turn.
	initial begin
		error_count = 0;
		result_idx = 0;
		no_idle = 1'b0;
		rect_w_model = '0;
		rect_h_model = '0;
		kept_quads = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		first_of_text <= 1'b0;
		quad_left <= '0;
		quad_right <= '0;
		quad_bottom <= '0;
		quad_top <= '0;
		tex_u_left <= '0;
		tex_u_right <= '0;
		tex_v_bottom <= '0;
		tex_v_top <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= qrcuv_pkg::CFG_RECT_WIDTH;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_rect();
		test_clip_cases();
		test_rect_extremes();
		test_random_texts();

		// Give any stray result time to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/qrcuv_pkg.sv
rtl/core/qrcuv_ctrl.sv
rtl/core/qrcuv_dp.sv
rtl/core/quad_rect_clip_uv_core.sv
rtl/core/qrcuv_checker.sv
verif/quad_rect_clip_uv_core_tb.sv
